[rtl/cursor_move_sequence_generator_macros.svh]
// Assertion macros for the cursor move sequence generator RTL
`ifndef CURSOR_MOVE_SEQUENCE_GENERATOR_MACROS_SVH
`define CURSOR_MOVE_SEQUENCE_GENERATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CMSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CMSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cmsg_pkg.sv]
// Types, codes and microcode table of the cursor move sequence generator
package cmsg_pkg;

  localparam int LINE_LEN = 64;
  localparam int COL_W    = $clog2(LINE_LEN);

  localparam logic [7:0] ESC_CODE   = 8'h1B;
  localparam logic [7:0] CR_CODE    = 8'h0D;
  localparam logic [7:0] LBRKT_CODE = 8'h5B;
  localparam logic [7:0] FWD_CMD    = 8'h43;
  localparam logic [7:0] BACK_CMD   = 8'h44;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;

  typedef enum logic [2:0] {
    REG_ANSI_EN    = 3'd0,
    REG_BS_CODE    = 3'd1,
    REG_END_LEN    = 3'd2,
    REG_END_BYTES  = 3'd3,
    REG_LINE_WIDTH = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_RUN
  } st_e;

  typedef enum logic [3:0] {
    SRC_ESC,
    SRC_BRKT,
    SRC_TENS,
    SRC_ONES,
    SRC_CMD,
    SRC_CR,
    SRC_LINE,
    SRC_END,
    SRC_BS
  } src_e;

  typedef enum logic [1:0] {
    RPT_ONCE,
    RPT_CNT_A,
    RPT_CNT_B
  } rpt_e;

  typedef enum logic {
    JMP_NONE,
    JMP_ONE_DIGIT
  } jmp_e;

  typedef enum logic [3:0] {
    PC_ESC,
    PC_BRKT,
    PC_TENS,
    PC_ONES,
    PC_CMD,
    PC_CR,
    PC_LINE,
    PC_END,
    PC_BS
  } pc_e;

  typedef struct packed {
    src_e src;
    rpt_e rpt;
    jmp_e jmp;
    pc_e  jmp_to;
    pc_e  nxt;
  } uword_t;

  typedef struct packed {
    logic             start;
    pc_e              entry;
    logic [COL_W-1:0] cnt_a;
    logic [COL_W-1:0] cnt_b;
    logic [COL_W-1:0] addr;
    logic [COL_W-1:0] total;
    logic [3:0]       tens;
    logic [3:0]       ones;
    logic             fwd;
  } plan_t;

  function automatic uword_t ucode_rom(pc_e pc);
    uword_t w;
    case (pc)
      PC_ESC:  w = '{SRC_ESC,  RPT_ONCE,  JMP_NONE,      PC_ESC,  PC_BRKT};
      PC_BRKT: w = '{SRC_BRKT, RPT_ONCE,  JMP_NONE,      PC_ESC,  PC_TENS};
      PC_TENS: w = '{SRC_TENS, RPT_ONCE,  JMP_ONE_DIGIT, PC_ONES, PC_ONES};
      PC_ONES: w = '{SRC_ONES, RPT_ONCE,  JMP_NONE,      PC_ESC,  PC_CMD};
      PC_CMD:  w = '{SRC_CMD,  RPT_ONCE,  JMP_NONE,      PC_ESC,  PC_ESC};
      PC_CR:   w = '{SRC_CR,   RPT_ONCE,  JMP_NONE,      PC_ESC,  PC_LINE};
      PC_LINE: w = '{SRC_LINE, RPT_CNT_A, JMP_NONE,      PC_ESC,  PC_ESC};
      PC_END:  w = '{SRC_END,  RPT_CNT_A, JMP_NONE,      PC_ESC,  PC_BS};
      PC_BS:   w = '{SRC_BS,   RPT_CNT_B, JMP_NONE,      PC_ESC,  PC_ESC};
      default: w = '{SRC_ESC,  RPT_ONCE,  JMP_NONE,      PC_ESC,  PC_ESC};
    endcase
    return w;
  endfunction

endpackage

[rtl/cursor_move_sequence_generator.sv]
// Top level: a store word writes one byte of the 64-column line buffer; a move word is accepted,
// planned, then the microcode sequencer emits its bytes one byte a cycle while the output is not
// stalled (an ANSI escape with a single digit takes a step that emits nothing to skip the tens
// digit), and the block returns to idle; a move emits n bytes, n up to 63.
// A move to the current column emits nothing and ends in its accept cycle. Line bytes are read
// from a RAM with registered read, prefetched one address ahead by the sequencer.
module cursor_move_sequence_generator import cmsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // position[5:0], char_value[13:6], zero[15:14]
  input  logic        s_axis_tuser,   // req_type[0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  st_e              state_q, state_d;
  logic [COL_W-1:0] cursor_q, cursor_d;
  logic [COL_W-1:0] old_q, old_d;
  logic [COL_W-1:0] tgt_q, tgt_d;

  logic        ansi_en_q;
  logic [7:0]  bs_code_q;
  logic [2:0]  end_len_q;
  logic [31:0] end_bytes_q;
  logic [6:0]  line_width_q;

  logic             acc;
  logic             is_move;
  logic [COL_W-1:0] in_pos;
  logic [7:0]       in_char;
  logic             cfg_wr;

  logic             busy;
  logic [COL_W-1:0] line_addr;
  logic [7:0]       line_data;
  plan_t            plan;

  // plan datapath
  logic             back;
  logic [COL_W-1:0] delta;
  logic [7:0]       dist8;
  logic [7:0]       escn8;
  logic [7:0]       rtn8;
  logic [2:0]       elen;
  logic             end_ok;
  logic [7:0]       ca8;
  logic [7:0]       bs_tail8;
  logic             use_end;
  logic [13:0]      tens_prod;
  logic [3:0]       tens;
  logic [COL_W-1:0] tens_x10;

  assign in_pos  = s_axis_tdata[5:0];
  assign in_char = s_axis_tdata[13:6];
  assign is_move = s_axis_tuser;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      REG_ANSI_EN:    prdata = {31'd0, ansi_en_q};
      REG_BS_CODE:    prdata = {24'd0, bs_code_q};
      REG_END_LEN:    prdata = {29'd0, end_len_q};
      REG_END_BYTES:  prdata = end_bytes_q;
      REG_LINE_WIDTH: prdata = {25'd0, line_width_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ansi_en_q    <= 1'b0;
      bs_code_q    <= 8'h08;
      end_len_q    <= 3'd0;
      end_bytes_q  <= 32'd0;
      line_width_q <= 7'd64;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ANSI_EN:    ansi_en_q    <= pwdata[0];
        REG_BS_CODE:    bs_code_q    <= pwdata[7:0];
        REG_END_LEN:    end_len_q    <= pwdata[2:0];
        REG_END_BYTES:  end_bytes_q  <= pwdata;
        REG_LINE_WIDTH: line_width_q <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    cursor_d = cursor_q;
    old_d    = old_q;
    tgt_d    = tgt_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && is_move) begin
          cursor_d = in_pos;
          old_d    = cursor_q;
          tgt_d    = in_pos;
          if (in_pos != cursor_q) begin
            state_d = ST_PLAN;
          end
        end
      end
      ST_PLAN: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (!busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_q <= old_d;
    tgt_q <= tgt_d;
  end

  assign back      = (tgt_q < old_q);
  assign delta     = back ? (old_q - tgt_q) : (tgt_q - old_q);
  assign dist8     = {2'd0, delta};
  assign escn8     = (delta >= COL_W'(10)) ? 8'd5 : 8'd4;
  assign rtn8      = {2'd0, tgt_q} + 8'd1;
  assign elen      = (end_len_q > 3'd4) ? 3'd4 : end_len_q;
  assign end_ok    = (elen != 3'd0) && (line_width_q >= {1'b0, tgt_q});
  assign bs_tail8  = {1'b0, line_width_q} - {2'd0, tgt_q};
  assign ca8       = {5'd0, elen} + bs_tail8;
  assign use_end   = end_ok && (ca8 < dist8);
  assign tens_prod = {8'd0, delta} * 14'd205;
  assign tens      = {1'b0, tens_prod[13:11]};
  assign tens_x10  = {2'd0, tens} * COL_W'(10);

  always_comb begin
    plan       = '0;
    plan.start = (state_q == ST_PLAN);
    plan.tens  = tens;
    plan.ones  = 4'(delta - tens_x10);
    plan.fwd   = !back;
    plan.entry = PC_ESC;
    plan.total = escn8[COL_W-1:0];
    if (back) begin
      if (dist8 <= rtn8) begin
        if (!(ansi_en_q && (escn8 < dist8))) begin
          plan.entry = PC_BS;
          plan.cnt_b = delta;
          plan.total = delta;
        end
      end else if (!(ansi_en_q && (escn8 < rtn8))) begin
        plan.entry = PC_CR;
        plan.cnt_a = tgt_q;
        plan.total = rtn8[COL_W-1:0];
      end
    end else if (use_end) begin
      if (!(ansi_en_q && (escn8 < ca8))) begin
        plan.entry = PC_END;
        plan.cnt_a = {3'd0, elen};
        plan.cnt_b = bs_tail8[COL_W-1:0];
        plan.total = ca8[COL_W-1:0];
      end
    end else if (!(ansi_en_q && (escn8 < dist8))) begin
      plan.entry = PC_LINE;
      plan.cnt_a = delta;
      plan.addr  = old_q;
      plan.total = delta;
    end
  end

  cmsg_ram #(
    .Width(8),
    .Depth(LINE_LEN)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (acc && !is_move),
    .waddr_i(in_pos),
    .wdata_i(in_char),
    .raddr_i(line_addr),
    .rdata_o(line_data)
  );

  cmsg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_i       (plan),
    .bs_code_i    (bs_code_q),
    .end_bytes_i  (end_bytes_q),
    .line_data_i  (line_data),
    .line_addr_o  (line_addr),
    .busy_o       (busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

[rtl/cmsg_ram.sv]
// Generic single-write, single-read RAM with registered read data
module cmsg_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cmsg_seq.sv]
// Microcoded byte sequencer with output register for the move sequences
`include "cursor_move_sequence_generator_macros.svh"

module cmsg_seq import cmsg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  plan_t            plan_i,
  input  logic [7:0]       bs_code_i,
  input  logic [31:0]      end_bytes_i,
  input  logic [7:0]       line_data_i,
  output logic [COL_W-1:0] line_addr_o,
  output logic             busy_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
  output logic             m_axis_tlast
);

  logic             busy_q, busy_d;
  pc_e              pc_q, pc_d;
  logic [COL_W-1:0] cnt_a_q, cnt_a_d;
  logic [COL_W-1:0] cnt_b_q, cnt_b_d;
  logic [COL_W-1:0] addr_q, addr_d;
  logic [COL_W-1:0] tot_q, tot_d;
  logic [3:0]       tens_q, tens_d;
  logic [3:0]       ones_q, ones_d;
  logic             fwd_q, fwd_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;

  uword_t     uw;
  logic       slot;
  logic       jump;
  logic       emit;
  logic [7:0] byte_sel;

  assign uw   = ucode_rom(pc_q);
  assign slot = !ovalid_q || m_axis_tready;
  assign jump = busy_q && (uw.jmp == JMP_ONE_DIGIT) && (tens_q == 4'd0);
  assign emit = busy_q && !jump && slot;

  always_comb begin
    case (uw.src)
      SRC_ESC:  byte_sel = ESC_CODE;
      SRC_BRKT: byte_sel = LBRKT_CODE;
      SRC_TENS: byte_sel = DIGIT_ZERO + {4'd0, tens_q};
      SRC_ONES: byte_sel = DIGIT_ZERO + {4'd0, ones_q};
      SRC_CMD:  byte_sel = fwd_q ? FWD_CMD : BACK_CMD;
      SRC_CR:   byte_sel = CR_CODE;
      SRC_LINE: byte_sel = line_data_i;
      SRC_END:  byte_sel = end_bytes_i[{addr_q[1:0], 3'b000} +: 8];
      SRC_BS:   byte_sel = bs_code_i;
      default:  byte_sel = bs_code_i;
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    pc_d     = pc_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    addr_d   = addr_q;
    tot_d    = tot_q;
    tens_d   = tens_q;
    ones_d   = ones_q;
    fwd_d    = fwd_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;

    if (plan_i.start) begin
      busy_d  = 1'b1;
      pc_d    = plan_i.entry;
      cnt_a_d = plan_i.cnt_a;
      cnt_b_d = plan_i.cnt_b;
      addr_d  = plan_i.addr;
      tot_d   = plan_i.total;
      tens_d  = plan_i.tens;
      ones_d  = plan_i.ones;
      fwd_d   = plan_i.fwd;
    end else if (jump) begin
      pc_d = uw.jmp_to;
    end else if (emit) begin
      tot_d  = tot_q - COL_W'(1);
      busy_d = (tot_q != COL_W'(1));
      case (uw.rpt)
        RPT_ONCE: begin
          pc_d = uw.nxt;
        end
        RPT_CNT_A: begin
          cnt_a_d = cnt_a_q - COL_W'(1);
          addr_d  = addr_q + COL_W'(1);
          if (cnt_a_q == COL_W'(1)) begin
            pc_d = uw.nxt;
          end
        end
        RPT_CNT_B: begin
          cnt_b_d = cnt_b_q - COL_W'(1);
          if (cnt_b_q == COL_W'(1)) begin
            pc_d = uw.nxt;
          end
        end
        default: begin
          pc_d = uw.nxt;
        end
      endcase
    end

    if (emit) begin
      ovalid_d = 1'b1;
      obyte_d  = byte_sel;
      olast_d  = (tot_q == COL_W'(1));
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pc_q     <= PC_ESC;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pc_q     <= pc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_a_q <= cnt_a_d;
    cnt_b_q <= cnt_b_d;
    addr_q  <= addr_d;
    tot_q   <= tot_d;
    tens_q  <= tens_d;
    ones_q  <= ones_d;
    fwd_q   <= fwd_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign line_addr_o   = addr_d;
  assign busy_o        = busy_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tlast  = olast_q;

  `CMSG_ASSERT_IMP(a_busy_has_work, busy_q, tot_q != '0, "sequencer busy with no bytes left")
  `CMSG_ASSERT_IMP(a_start_when_free, plan_i.start, !busy_q, "sequence started while busy")
  `CMSG_ASSERT_NXT(a_last_ends_run, emit && (tot_q == COL_W'(1)), !busy_q && m_axis_tlast, "last word did not end the run")
  `CMSG_ASSERT_IMP(a_count_live, busy_q && (uw.rpt == RPT_CNT_A), cnt_a_q != '0, "repeat step entered with empty count")

endmodule

[tb/cursor_move_checker.sv]
// Checker for the cursor move sequence generator: predicts move sequences and compares them
module cursor_move_checker import cmsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // position[5:0], char_value[13:6], zero[15:14]
  input  logic        s_axis_tuser,   // req_type[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          err_cnt,
  output int          pending
);

  typedef struct packed {
    logic [7:0] code;
    logic       tail;
  } seq_byte_t;

  seq_byte_t        expected_bytes[$];
  logic             ansi_on;
  logic [7:0]       bs_code;
  logic [2:0]       end_len;
  logic [31:0]      end_bytes;
  logic [6:0]       line_w;
  logic [COL_W-1:0] cursor_col;
  logic [7:0]       line_mem[LINE_LEN];

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic plan_move(input logic [COL_W-1:0] target);
    int unsigned old_col, delta, esc_len, bsp, rtn, elen, ca, i;
    logic [7:0]  esc_seq[$];
    logic [7:0]  seq[$];
    bit          use_end;
    old_col    = cursor_col;
    cursor_col = target;
    if (target == old_col) return;
    delta   = target > old_col ? target - old_col : old_col - target;
    esc_len = 'hFFFF;
    if (ansi_on) begin
      esc_seq.push_back(ESC_CODE);
      esc_seq.push_back(LBRKT_CODE);
      if (delta >= 10) esc_seq.push_back(DIGIT_ZERO + 8'(delta / 10));
      esc_seq.push_back(DIGIT_ZERO + 8'(delta % 10));
      esc_seq.push_back(target > old_col ? FWD_CMD : BACK_CMD);
      esc_len = esc_seq.size();
    end
    if (target < old_col) begin
      bsp = delta;
      rtn = 1 + target;
      if (bsp <= rtn) begin
        if (esc_len < bsp) seq = esc_seq;
        else for (i = 0; i < bsp; i++) seq.push_back(bs_code);
      end else if (esc_len < rtn) begin
        seq = esc_seq;
      end else begin
        seq.push_back(CR_CODE);
        for (i = 0; i < target; i++) seq.push_back(line_mem[i]);
      end
    end else begin
      elen    = end_len > 4 ? 4 : end_len;
      use_end = 1'b0;
      ca      = 0;
      if (elen != 0 && line_w >= target) begin
        ca      = elen + line_w - target;
        use_end = ca < delta;
      end
      if (use_end) begin
        if (esc_len < ca) begin
          seq = esc_seq;
        end else begin
          for (i = 0; i < elen; i++) seq.push_back(end_bytes[8*i +: 8]);
          for (i = elen; i < ca; i++) seq.push_back(bs_code);
        end
      end else if (esc_len < delta) begin
        seq = esc_seq;
      end else begin
        for (i = 0; i < delta; i++) seq.push_back(line_mem[(old_col + i) % LINE_LEN]);
      end
    end
    foreach (seq[k]) expected_bytes.push_back('{seq[k], k == seq.size() - 1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    seq_byte_t want;
    if (!rst_ni) begin
      ansi_on    = 1'b0;
      bs_code    = 8'h08;
      end_len    = 3'd0;
      end_bytes  = 32'd0;
      line_w     = 7'd64;
      cursor_col = '0;
      err_cnt    = 0;
      expected_bytes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected byte %02h", m_axis_tdata));
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.code)
            report($sformatf("byte %02h, want %02h", m_axis_tdata, want.code));
          if (m_axis_tlast !== want.tail)
            report($sformatf("last %b, want %b", m_axis_tlast, want.tail));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_ANSI_EN:    ansi_on   = pwdata[0];
          REG_BS_CODE:    bs_code   = pwdata[7:0];
          REG_END_LEN:    end_len   = pwdata[2:0];
          REG_END_BYTES:  end_bytes = pwdata;
          REG_LINE_WIDTH: line_w    = pwdata[6:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) plan_move(s_axis_tdata[5:0]);
        else line_mem[s_axis_tdata[5:0]] = s_axis_tdata[13:6];
      end
    end
    pending = expected_bytes.size();
  end

endmodule

[tb/tb_cursor_move_sequence_generator.sv]
// Testbench top for the cursor move sequence generator: stimulus, idling and verdict
module tb_cursor_move_sequence_generator;
  import cmsg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // position[5:0], char_value[13:6], zero[15:14]
  logic        s_axis_tuser;   // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_byte[7:0]
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          err_cnt;
  int          pending;

  int          burst_left = 0;
  bit          steady;
  int          rx_mode = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age = 0;
  int          idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  cursor_move_sequence_generator dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cursor_move_checker mon (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .err_cnt, .pending
  );

  always @(posedge clk_i) begin
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        m_axis_tready <= stall_pat[0];
        stall_pat     <= (pat_age == 63) ? (16'($urandom) | 16'h1)
                                         : {stall_pat[0], stall_pat[15:1]};
      end
    endcase
    pat_age <= (pat_age + 1) % 64;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic req, input logic [5:0] pos, input logic [7:0] chr);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, chr, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic move_to(input logic [5:0] pos);
    send_word(1'b1, pos, 8'($urandom));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic ansi, input logic [7:0] bs, input logic [2:0] elen,
                            input logic [31:0] ebytes, input logic [6:0] width);
    apb_write(REG_ANSI_EN, {31'd0, ansi});
    apb_write(REG_BS_CODE, {24'd0, bs});
    apb_write(REG_END_LEN, {29'd0, elen});
    apb_write(REG_END_BYTES, ebytes);
    apb_write(REG_LINE_WIDTH, {25'd0, width});
  endtask

  initial begin
    int          phase;
    int          n;
    logic [5:0]  tgt;
    logic [7:0]  chr;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the line so that every resend reads written bytes
    steady = 1'b0;
    for (n = 0; n < LINE_LEN; n++) begin
      chr = (n == 5) ? 8'h00 : (n == 6) ? 8'hFF : 8'($urandom);
      send_word(1'b0, 6'(n), chr);
    end

    move_to(6'd63);
    move_to(6'd0);
    move_to(6'd63);
    move_to(6'd62);
    move_to(6'd62);
    send_word(1'b0, 6'd63, 8'hFF);
    move_to(6'd1);
    move_to(6'd31);
    move_to(6'd0);
    settle();

    rx_mode = 1;
    set_config(1'b1, 8'h7F, 3'd3, 32'h00465B1B, 7'd64);
    move_to(6'd1);
    move_to(6'd40);
    move_to(6'd63);
    move_to(6'd52);
    move_to(6'd50);
    move_to(6'd0);
    move_to(6'd10);
    move_to(6'd9);
    settle();

    rx_mode = 2;
    set_config(1'b0, 8'h00, 3'd7, 32'hFFFFFFFF, 7'd1);
    move_to(6'd0);
    move_to(6'd1);
    move_to(6'd63);
    move_to(6'd0);
    settle();

    for (phase = 0; phase < 8; phase++) begin
      rx_mode = phase % 3;
      steady  = (phase % 3 == 1);
      if (phase == 7)
        set_config(1'b0, 8'hFF, 3'd4, 32'($urandom), 7'd64);
      else
        set_config(1'($urandom), 8'($urandom), 3'($urandom_range(0, 7)), 32'($urandom),
                   7'($urandom_range(0, 1) ? $urandom_range(40, 64) : $urandom_range(1, 64)));
      for (n = 0; n < 12; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          send_word(1'b0, 6'($urandom), 8'($urandom));
        end else begin
          case ($urandom_range(0, 4))
            0:       tgt = 6'd0;
            1:       tgt = 6'd63;
            default: tgt = 6'($urandom);
          endcase
          move_to(tgt);
        end
      end
      settle();
    end

    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cmsg_pkg.sv
rtl/cmsg_ram.sv
rtl/cmsg_seq.sv
rtl/cursor_move_sequence_generator.sv
tb/cursor_move_checker.sv
tb/tb_cursor_move_sequence_generator.sv
